[sv/bf_pkg.sv]
package bf_pkg;

  typedef logic [5:0] vertex_t;
  typedef logic [6:0] vcount_t;

  // configuration register indexes
  localparam logic CFG_VERTEX_COUNT = 1'b0;
  localparam logic CFG_SOURCE_VERTEX = 1'b1;

  localparam vcount_t VCOUNT_RESET = 7'd64;

  localparam logic signed [31:0] DIST_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] DIST_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic               edge_present;
    vertex_t            edge_from;
    vertex_t            edge_to;
    logic signed [15:0] edge_weight;
    logic               last_edge;
  } in_word_t;

  typedef struct packed {
    vertex_t            vertex_index;
    logic signed [31:0] distance;
    logic               unreachable;
    logic               negative_cycle;
    logic               last_vertex;
  } out_word_t;

  // one stored edge
  typedef struct packed {
    vertex_t            src;
    vertex_t            dst;
    logic signed [15:0] weight;
  } edge_rec_t;

  // write/clear request to the distance store
  typedef struct packed {
    logic               en;
    logic               clr;
    vertex_t            addr;
    logic signed [31:0] data;
  } dist_wr_t;

endpackage

[sv/bf_edge_mem.sv]
module bf_edge_mem import bf_pkg::*; #(
  parameter int MAX_EDGES = 1024,
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  edge_rec_t     wr_data,
  input  logic [AW-1:0] rd_addr,
  output edge_rec_t     rd_data
);

  edge_rec_t mem [MAX_EDGES];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[sv/bf_dist_mem.sv]
module bf_dist_mem import bf_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int VW = 6
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dist_wr_t                wr,
  input  logic [VW-1:0]           rd_addr_a,
  input  logic [VW-1:0]           rd_addr_b,
  output logic signed [31:0]      rd_data_a,
  output logic signed [31:0]      rd_data_b,
  output logic [MAX_VERTICES-1:0] valid
);

  logic signed [31:0] mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] valid_r;
  logic [MAX_VERTICES-1:0] valid_nxt;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[VW-1:0]] <= wr.data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

  // reachable flags: clear all at graph start, set on every write
  always_comb begin
    valid_nxt = wr.clr ? '0 : valid_r;
    if (wr.en) begin
      valid_nxt[wr.addr[VW-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign valid = valid_r;

endmodule

[sv/bellman_ford_shortest_paths.sv]
// Bellman-Ford single-source shortest paths. Edge words load one per cycle
// into an edge table (in_ready is high only while loading). The word with
// last_edge set starts the run: a setup step, then passes over the E stored
// edges, where every edge does a read of the edge table, a two-port read of
// the distance memory and, if it shortens a path, a write back before the
// next edge starts. Passes repeat until one changes nothing or vertex_count
// passes have run; negative_cycle is set when the last of them still changed
// a distance. One result word per vertex then goes out, each held until
// out_ready takes it; then the block loads again, edge table empty. Edges beyond
// MAX_EDGES are dropped; distances saturate to the signed 32-bit range.
module bellman_ford_shortest_paths import bf_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_addr,
  input  logic [6:0] cfg_wdata
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam logic [CW-1:0] EDGE_LIMIT = CW'(MAX_EDGES);
  localparam vcount_t NV_MAX = vcount_t'(MAX_VERTICES);

  typedef enum logic [9:0] {
    S_LOAD      = 10'b00_0000_0001,
    S_INIT      = 10'b00_0000_0010,
    S_PSTART    = 10'b00_0000_0100,
    S_EREAD     = 10'b00_0000_1000,
    S_DREAD     = 10'b00_0001_0000,
    S_RELAX     = 10'b00_0010_0000,
    S_PEND      = 10'b00_0100_0000,
    S_EMIT_RD   = 10'b00_1000_0000,
    S_EMIT_CAP  = 10'b01_0000_0000,
    S_EMIT_WAIT = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  vcount_t         vcount_r, vcount_nxt;
  vertex_t         source_r, source_nxt;
  logic [CW-1:0]   ecount_r, ecount_nxt;
  logic [CW-1:0]   eidx_r, eidx_nxt;
  vcount_t         pass_r, pass_nxt;
  logic            changed_r, changed_nxt;
  logic            neg_r, neg_nxt;
  vertex_t         vidx_r, vidx_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_word_t       out_data_r, out_data_nxt;

  vcount_t                 nv;
  logic                    in_fire;
  logic                    edge_wr;
  edge_rec_t               edge_wdata;
  edge_rec_t               edge_q;
  dist_wr_t                dwr;
  logic [VW-1:0]           rd_addr_a;
  logic signed [31:0]      dist_a, dist_b;
  logic [MAX_VERTICES-1:0] dvalid;
  logic signed [32:0]      sum;
  logic signed [31:0]      cand;
  logic                    edge_ok;
  logic                    take;

  // effective vertex count
  always_comb begin
    if (vcount_r == '0) begin
      nv = 7'd1;
    end else if (vcount_r > NV_MAX) begin
      nv = NV_MAX;
    end else begin
      nv = vcount_r;
    end
  end

  assign in_ready = (state_r == S_LOAD);
  assign in_fire  = in_valid && in_ready;
  assign edge_wr  = in_fire && in_data.edge_present && (ecount_r < EDGE_LIMIT);

  assign edge_wdata.src    = in_data.edge_from;
  assign edge_wdata.dst    = in_data.edge_to;
  assign edge_wdata.weight = in_data.edge_weight;

  bf_edge_mem #(
    .MAX_EDGES(MAX_EDGES),
    .AW(AW)
  ) u_edges (
    .clk(clk),
    .wr_en(edge_wr),
    .wr_addr(ecount_r[AW-1:0]),
    .wr_data(edge_wdata),
    .rd_addr(eidx_r[AW-1:0]),
    .rd_data(edge_q)
  );

  assign rd_addr_a = (state_r == S_EMIT_RD) ? vidx_r[VW-1:0] : edge_q.src[VW-1:0];

  bf_dist_mem #(
    .MAX_VERTICES(MAX_VERTICES),
    .VW(VW)
  ) u_dist (
    .clk(clk),
    .rst_n(rst_n),
    .wr(dwr),
    .rd_addr_a(rd_addr_a),
    .rd_addr_b(edge_q.dst[VW-1:0]),
    .rd_data_a(dist_a),
    .rd_data_b(dist_b),
    .valid(dvalid)
  );

  // candidate distance with saturation
  always_comb begin
    sum = {dist_a[31], dist_a} + 33'(edge_q.weight);
    if (sum[32] != sum[31]) begin
      cand = sum[32] ? DIST_MIN : DIST_MAX;
    end else begin
      cand = sum[31:0];
    end
  end

  assign edge_ok = ({1'b0, edge_q.src} < nv) && ({1'b0, edge_q.dst} < nv)
                   && dvalid[edge_q.src[VW-1:0]];
  assign take = edge_ok && (!dvalid[edge_q.dst[VW-1:0]] || (cand < dist_b));

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    vcount_nxt    = vcount_r;
    source_nxt    = source_r;
    ecount_nxt    = ecount_r;
    eidx_nxt      = eidx_r;
    pass_nxt      = pass_r;
    changed_nxt   = changed_r;
    neg_nxt       = neg_r;
    vidx_nxt      = vidx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    dwr           = '0;

    if (cfg_we) begin
      case (cfg_addr)
        CFG_VERTEX_COUNT:  vcount_nxt = cfg_wdata;
        CFG_SOURCE_VERTEX: source_nxt = cfg_wdata[5:0];
        default: ;
      endcase
    end

    case (state_r)
      S_LOAD: begin
        if (edge_wr) begin
          ecount_nxt = ecount_r + CW'(1);
        end
        if (in_fire && in_data.last_edge) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        dwr.clr   = 1'b1;
        dwr.en    = ({1'b0, source_r} < nv);
        dwr.addr  = source_r;
        dwr.data  = '0;
        pass_nxt  = '0;
        state_nxt = S_PSTART;
      end
      S_PSTART: begin
        changed_nxt = 1'b0;
        eidx_nxt    = '0;
        state_nxt   = (ecount_r == '0) ? S_PEND : S_EREAD;
      end
      S_EREAD: begin
        state_nxt = S_DREAD;
      end
      S_DREAD: begin
        state_nxt = S_RELAX;
      end
      S_RELAX: begin
        if (take) begin
          dwr.en      = 1'b1;
          dwr.addr    = edge_q.dst;
          dwr.data    = cand;
          changed_nxt = 1'b1;
        end
        eidx_nxt  = eidx_r + CW'(1);
        state_nxt = (eidx_r + CW'(1) == ecount_r) ? S_PEND : S_EREAD;
      end
      S_PEND: begin
        if ((pass_r + 7'd1 < nv) && changed_r) begin
          pass_nxt  = pass_r + 7'd1;
          state_nxt = S_PSTART;
        end else begin
          neg_nxt   = changed_r;
          vidx_nxt  = '0;
          state_nxt = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_CAP;
      end
      S_EMIT_CAP: begin
        out_data_nxt.vertex_index   = vidx_r;
        out_data_nxt.distance       = dvalid[vidx_r[VW-1:0]] ? dist_a : '0;
        out_data_nxt.unreachable    = !dvalid[vidx_r[VW-1:0]];
        out_data_nxt.negative_cycle = neg_r;
        out_data_nxt.last_vertex    = ({1'b0, vidx_r} + 7'd1 == nv);
        out_valid_nxt = 1'b1;
        state_nxt     = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_data_r.last_vertex) begin
            ecount_nxt = '0;
            state_nxt  = S_LOAD;
          end else begin
            vidx_nxt  = vidx_r + 6'd1;
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      vcount_r    <= VCOUNT_RESET;
      source_r    <= '0;
      ecount_r    <= '0;
      eidx_r      <= '0;
      pass_r      <= '0;
      changed_r   <= 1'b0;
      neg_r       <= 1'b0;
      vidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vcount_r    <= vcount_nxt;
      source_r    <= source_nxt;
      ecount_r    <= ecount_nxt;
      eidx_r      <= eidx_nxt;
      pass_r      <= pass_nxt;
      changed_r   <= changed_nxt;
      neg_r       <= neg_nxt;
      vidx_r      <= vidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_no_load_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted while a result is pending");

  a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last_vertex) |=> (in_ready && ecount_r == '0))
    else $error("edge table not emptied after last vertex");

  a_vertex_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_data.vertex_index} < nv))
    else $error("reported vertex beyond vertex count");

  a_edge_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ecount_r <= EDGE_LIMIT)
    else $error("edge count beyond table size");

endmodule
